>>> rtl/core/scus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scus_pkg: shared types for the start-code unit splitter
// Scanner state, result item and result group types, reset state constant.
// ----------------------------------------------------------------------------
package scus_pkg;

	localparam int MaxResults = 4;

	typedef struct packed {
		logic [2:0][7:0] win;       // lookahead window, oldest at index 0
		logic [1:0]      win_cnt;   // bytes held in window
		logic [1:0]      seen;      // bytes taken, saturating at 3
		logic            in_first;  // still releasing the leading unit
		logic            keep;      // leading unit is emitted
		logic            unit_open; // a unit has started and not ended
	} scan_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       unit_first;
		logic       unit_final;
		logic       run_last;
	} result_t;

	typedef result_t [MaxResults-1:0] res_group_t;

	localparam scan_state_t StateReset = '{
		win:       '0,
		win_cnt:   2'd0,
		seen:      2'd0,
		in_first:  1'b1,
		keep:      1'b0,
		unit_open: 1'b0
	};

endpackage

>>> rtl/core/scus_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scus_step: one-byte scan step
// Shifts a byte into the lookahead window, detects the 00 00 01 boundary,
// releases bytes with unit marks and flushes the window on the final byte.
// ----------------------------------------------------------------------------
module scus_step import scus_pkg::*; (
	input  scan_state_t cur,
	input  logic [7:0]  data,
	input  logic        fin,
	output scan_state_t nxt,
	output res_group_t  res,
	output logic [2:0]  res_cnt
);

	always_comb begin
		logic [2:0][7:0] w;
		logic [1:0]      c;
		logic [1:0]      i;
		logic            keep_n;
		logic            ifu;
		logic            uo;
		logic            drop;
		logic [2:0]      n;
		logic [1:0]      seen_n;
		logic [3:0]      sv;
		logic [3:0][7:0] sb;
		logic [3:0]      se;

		w    = cur.win;
		c    = cur.win_cnt;
		drop = 1'b0;

		// release from a full window, boundary when 00 00 is followed by 01
		sv[0] = (cur.win_cnt == 2'd3);
		sb[0] = cur.win[0];
		se[0] = (cur.win[1] == 8'h00) && (cur.win[2] == 8'h00) && (data == 8'h01);
		if (sv[0]) begin
			w[0] = cur.win[1];
			w[1] = cur.win[2];
			c    = 2'd2;
		end

		// leading unit kept only if it opens 00 00 xx with xx nonzero
		keep_n = cur.keep;
		if ((cur.seen == 2'd2) && (c == 2'd2)) begin
			keep_n = (w[0] == 8'h00) && (w[1] == 8'h00) && (data != 8'h00);
		end

		w[c] = data;
		c    = c + 2'd1;
		seen_n = (cur.seen == 2'd3) ? 2'd3 : cur.seen + 2'd1;

		// flush slots
		for (int k = 1; k < MaxResults; k++) begin
			i     = 2'(k - 1);
			sv[k] = fin && (i < c);
			sb[k] = w[i];
			se[k] = (i == c - 2'd1);
		end

		ifu = cur.in_first;
		uo  = cur.unit_open;
		n   = 3'd0;
		res = '0;
		for (int k = 0; k < MaxResults; k++) begin
			if (sv[k]) begin
				drop = ifu && !((k == 0) ? cur.keep : keep_n);
				if (se[k]) begin
					ifu = 1'b0;
				end
				if (!drop) begin
					res[n[1:0]] = '{out_byte: sb[k], unit_first: !uo,
						unit_final: se[k], run_last: 1'b0};
					uo = !se[k];
					n  = n + 3'd1;
				end
			end
		end
		if (n != 3'd0) begin
			res[2'(n - 3'd1)].run_last = 1'b1;
		end
		res_cnt = n;

		if (fin) begin
			nxt = StateReset;
		end else begin
			nxt = '{win: w, win_cnt: c, seen: seen_n, in_first: ifu,
				keep: keep_n, unit_open: uo};
		end
	end

endmodule

>>> rtl/core/start_code_unit_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_code_unit_splitter: access-unit splitter on 00 00 01 start codes
// Byte-wide elementary stream in, bytes out with first/last unit marks.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low. A byte passes an input
// register, the scan logic and a result group register, from which its
// results are shown. An ordinary byte causes at most one result; the final
// byte of a stream flushes the three-byte window and can cause up to four,
// which leave the result group register one per cycle while out_stall is
// low. A following byte that causes a result waits until they have all
// left. Bytes that cause no result never wait for the output side.
module start_code_unit_splitter import scus_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       unit_first,
	output logic       unit_final,
	output logic       run_last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;
	scan_state_t state_q;
	scan_state_t state_nxt;
	res_group_t  res;
	logic [2:0]  res_cnt;
	res_group_t  grp_q;
	logic [2:0]  grp_cnt_q;
	logic [1:0]  grp_idx_q;
	logic        take;
	logic        last_out;
	logic        grp_free;
	logic        adv;
	logic        in_take;

	scus_step u_step (
		.cur     (state_q),
		.data    (byte_s1),
		.fin     (fin_s1),
		.nxt     (state_nxt),
		.res     (res),
		.res_cnt (res_cnt)
	);

	assign out_valid  = (grp_cnt_q != 3'd0);
	assign out_byte   = grp_q[grp_idx_q].out_byte;
	assign unit_first = grp_q[grp_idx_q].unit_first;
	assign unit_final = grp_q[grp_idx_q].unit_final;
	assign run_last   = grp_q[grp_idx_q].run_last;

	assign take     = out_valid && !out_stall;
	assign last_out = ({1'b0, grp_idx_q} == grp_cnt_q - 3'd1);
	assign grp_free = !out_valid || (take && last_out);
	assign adv      = valid_s1 && ((res_cnt == 3'd0) || grp_free);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			fin_s1  <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q <= 3'd0;
			grp_idx_q <= 2'd0;
		end else if (adv && (res_cnt != 3'd0)) begin
			grp_cnt_q <= res_cnt;
			grp_idx_q <= 2'd0;
		end else if (take) begin
			if (last_out) begin
				grp_cnt_q <= 3'd0;
				grp_idx_q <= 2'd0;
			end else begin
				grp_idx_q <= grp_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (res_cnt != 3'd0)) begin
			grp_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, grp_idx_q} < grp_cnt_q))
		else $error("result index beyond group count");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_flush_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fin_s1) |=> (state_q.win_cnt == 2'd0) && state_q.in_first)
		else $error("scanner not back to stream start after final byte");

	a_window_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.win_cnt <= state_q.seen)
		else $error("window holds more bytes than were taken");
`endif

endmodule
